[sv/mbs_pkg.sv]
// ----------------------------------------------------------------------------
// mbs_pkg
// Shared constants and types of the meshlet bounding sphere block.
// ----------------------------------------------------------------------------
`default_nettype none

package mbs_pkg;

  localparam int unsigned VertexDepth = 4096;
  localparam int unsigned VertexAw    = $clog2(VertexDepth);
  localparam int unsigned TriLimit    = 128;
  localparam int unsigned PointDepth  = TriLimit * 3;
  localparam int unsigned PointAw     = $clog2(PointDepth);
  localparam int unsigned SumW        = 41;
  localparam int unsigned DistW       = 68;
  localparam int unsigned RootSteps   = DistW / 2;

  // configuration register indexes
  localparam logic [7:0] CfgMaxTriangles = 8'd0;
  localparam logic [7:0] CfgVertexLimit  = 8'd1;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  typedef struct packed {
    logic [23:0]             first_index;
    logic [7:0]              tri_cnt;
    logic [PointAw-1:0]      ref_cnt;
    logic signed [SumW-1:0]  sum_x;
    logic signed [SumW-1:0]  sum_y;
    logic signed [SumW-1:0]  sum_z;
    logic                    bank;
  } meshlet_t;

  typedef struct packed {
    logic               en;
    logic               bank;
    logic [PointAw-1:0] addr;
    point_t             pt;
  } pt_wr_t;

  typedef enum logic [4:0] {
    BsIdle = 5'b00001,
    BsDiv  = 5'b00010,
    BsWalk = 5'b00100,
    BsRoot = 5'b01000,
    BsDone = 5'b10000
  } back_state_e;

endpackage

`default_nettype wire

[sv/mbs_ifs.sv]
// ----------------------------------------------------------------------------
// mbs_ifs
// Valid/ready channels of the meshlet bounding sphere block.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbs_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [11:0] vertex_slot;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;
  logic [31:0] index_value;
  logic        end_of_mesh;
  modport source (output valid, mode, vertex_slot, coord_x, coord_y, coord_z,
                  index_value, end_of_mesh, input ready);
  modport sink   (input valid, mode, vertex_slot, coord_x, coord_y, coord_z,
                  index_value, end_of_mesh, output ready);
endinterface

interface mbs_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] first_index;
  logic [7:0]  triangle_count;
  logic [8:0]  reference_count;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] center_z;
  logic [32:0] sphere_radius;
  modport source (output valid, first_index, triangle_count, reference_count,
                  center_x, center_y, center_z, sphere_radius, input ready);
  modport sink   (input valid, first_index, triangle_count, reference_count,
                  center_x, center_y, center_z, sphere_radius, output ready);
endinterface

interface mbs_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[sv/meshlet_bounding_sphere_top.sv]
// ----------------------------------------------------------------------------
// meshlet_bounding_sphere_top
// Groups a triangle index stream into meshlets and emits a centroid sphere.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries vertex writes (mode 0) and triangle indices (mode 1).
//   cfg_ch writes max_triangles (index 0) and vertex_limit (index 1); it is
//          always ready and should only be used while the block is idle.
//   out_ch delivers one meshlet record per completed meshlet.
// An input transaction is accepted only once the previous one has left
//   stage 1 and while the queue is not full; the vertex store read and
//   the triangle/accumulate stage hold one item in flight. A meshlet runs from
//   its closing index to out_ch through stage 1, the queue hand-off, a
//   signed divide (one quotient bit per cycle), the point walk and a square
//   root (one bit per cycle); an empty meshlet skips divide, walk and root.
// A two-entry meshlet queue with banked point storage lets the front keep
//   accepting indices while the back works; besides the wait on stage 1,
//   the front stalls only when both banks are taken. A stalled receiver
//   holds the output register and then the back end; nothing is dropped.
// Reset clears the front counters, the back state and the queue; the vertex and point stores are
//   not cleared, so vertices must be written before they are referenced.
// ----------------------------------------------------------------------------
`default_nettype none

module meshlet_bounding_sphere_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  mbs_in_if.sink    in_ch,
  mbs_cfg_if.sink   cfg_ch,
  mbs_out_if.source out_ch
);

  logic              push, pop, q_valid, q_full;
  mbs_pkg::meshlet_t push_entry, head;
  mbs_pkg::pt_wr_t   pt_wr;

  mbs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .cfg_ch       (cfg_ch),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_entry_o (push_entry),
    .pt_wr_o      (pt_wr)
  );

  mbs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .head_o  (head)
  );

  mbs_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .head_i    (head),
    .pop_o     (pop),
    .pt_wr_i   (pt_wr),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

[sv/mbs_front.sv]
// ----------------------------------------------------------------------------
// mbs_front
// Vertex store, triangle grouping and per-meshlet accumulation.
// ----------------------------------------------------------------------------
`default_nettype none

module mbs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  mbs_in_if.sink            in_ch,
  mbs_cfg_if.sink           cfg_ch,
  input  logic              q_full_i,
  output logic              push_o,
  output mbs_pkg::meshlet_t push_entry_o,
  output mbs_pkg::pt_wr_t   pt_wr_o
);

  logic [7:0]  max_tri_q;
  logic [12:0] vlimit_q;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_tri_q <= 8'd64;
      vlimit_q  <= 13'd0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        mbs_pkg::CfgMaxTriangles: max_tri_q <= cfg_ch.data[7:0];
        mbs_pkg::CfgVertexLimit:  vlimit_q  <= cfg_ch.data[12:0];
        default: ;
      endcase
    end
  end

  logic [7:0] tri_lim;
  always_comb begin
    tri_lim = max_tri_q;
    if (max_tri_q == 8'd0) tri_lim = 8'd1;
    if (max_tri_q > 8'(mbs_pkg::TriLimit)) tri_lim = 8'(mbs_pkg::TriLimit);
  end

  // one item in flight: stage 1 must drain before the next transaction
  logic s1_v_q;
  logic accept;
  assign in_ch.ready = !s1_v_q && !q_full_i;
  assign accept      = in_ch.valid && in_ch.ready;

  logic s1_mode_q, s1_end_q, s1_inrange_q;
  logic inrange;
  assign inrange = (in_ch.index_value < 32'(vlimit_q)) &&
                   (in_ch.index_value < 32'(mbs_pkg::VertexDepth));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else         s1_v_q <= accept;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_mode_q    <= in_ch.mode;
      s1_end_q     <= in_ch.end_of_mesh;
      s1_inrange_q <= inrange;
    end
  end

  mbs_pkg::point_t vstore [mbs_pkg::VertexDepth];
  mbs_pkg::point_t vrd_q;

  always_ff @(posedge clk_i) begin
    if (accept && !in_ch.mode) begin
      vstore[in_ch.vertex_slot[mbs_pkg::VertexAw-1:0]] <=
        '{x: in_ch.coord_x, y: in_ch.coord_y, z: in_ch.coord_z};
    end
    vrd_q <= vstore[in_ch.index_value[mbs_pkg::VertexAw-1:0]];
  end

  // triangle and meshlet state
  logic [1:0]  pend_used_q, pend_used_d;
  logic [1:0]  pend_refs_q, pend_refs_d;
  logic signed [33:0] pend_sum_q [3];
  logic signed [33:0] pend_sum_d [3];
  logic [23:0] seen_q, seen_d;
  logic [7:0]  mtri_q, mtri_d;
  logic [mbs_pkg::PointAw-1:0] pc_q, pc_d;
  logic signed [mbs_pkg::SumW-1:0] sums_q [3];
  logic signed [mbs_pkg::SumW-1:0] sums_d [3];
  logic bank_q, bank_d;

  logic        proc, pv, emit;
  logic [7:0]  mtri_n;
  logic [mbs_pkg::PointAw-1:0] pc_n;
  logic signed [mbs_pkg::SumW-1:0] sums_n [3];
  logic signed [31:0] pa [3];
  logic [23:0] start;

  assign proc  = s1_v_q && s1_mode_q;
  assign pv    = proc && s1_inrange_q;
  assign pa[0] = vrd_q.x;
  assign pa[1] = vrd_q.y;
  assign pa[2] = vrd_q.z;
  assign start = seen_q - 24'(mtri_q);

  always_comb begin
    pend_used_d  = pend_used_q;
    pend_refs_d  = pend_refs_q;
    pend_sum_d   = pend_sum_q;
    seen_d       = seen_q;
    mtri_d       = mtri_q;
    pc_d         = pc_q;
    sums_d       = sums_q;
    bank_d       = bank_q;
    mtri_n       = mtri_q;
    pc_n         = pc_q;
    sums_n       = sums_q;
    emit         = 1'b0;
    push_o       = 1'b0;
    push_entry_o = '0;
    pt_wr_o      = '0;
    if (proc) begin
      if (pv) begin
        pt_wr_o.en   = 1'b1;
        pt_wr_o.bank = bank_q;
        pt_wr_o.addr = pc_q + mbs_pkg::PointAw'(pend_refs_q);
        pt_wr_o.pt   = vrd_q;
      end
      if (pend_used_q != 2'd2) begin
        pend_used_d = pend_used_q + 2'd1;
        pend_refs_d = pend_refs_q + 2'(pv);
        for (int a = 0; a < 3; a++) begin
          pend_sum_d[a] = pend_sum_q[a] + (pv ? 34'(pa[a]) : 34'sd0);
        end
      end else begin
        mtri_n = mtri_q + 8'd1;
        pc_n   = pc_q + mbs_pkg::PointAw'(pend_refs_q) + mbs_pkg::PointAw'(pv);
        for (int a = 0; a < 3; a++) begin
          sums_n[a] = sums_q[a] + mbs_pkg::SumW'(pend_sum_q[a]) +
                      (pv ? mbs_pkg::SumW'(pa[a]) : '0);
          pend_sum_d[a] = '0;
        end
        pend_used_d = 2'd0;
        pend_refs_d = 2'd0;
        seen_d      = seen_q + 24'd1;
        mtri_d      = mtri_n;
        pc_d        = pc_n;
        sums_d      = sums_n;
        if (mtri_n >= tri_lim) emit = 1'b1;
      end
      if (s1_end_q && mtri_n != 8'd0) emit = 1'b1;
      if (emit) begin
        push_o                   = 1'b1;
        push_entry_o.first_index = start + {start[22:0], 1'b0};
        push_entry_o.tri_cnt     = mtri_n;
        push_entry_o.ref_cnt     = pc_n;
        push_entry_o.sum_x       = sums_n[0];
        push_entry_o.sum_y       = sums_n[1];
        push_entry_o.sum_z       = sums_n[2];
        push_entry_o.bank        = bank_q;
        mtri_d = '0;
        pc_d   = '0;
        for (int a = 0; a < 3; a++) sums_d[a] = '0;
        bank_d = ~bank_q;
      end
      if (s1_end_q) begin
        // drop a trailing partial triangle and restart numbering
        pend_used_d = 2'd0;
        pend_refs_d = 2'd0;
        for (int a = 0; a < 3; a++) pend_sum_d[a] = '0;
        seen_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_used_q <= '0;
      pend_refs_q <= '0;
      seen_q      <= '0;
      mtri_q      <= '0;
      pc_q        <= '0;
      bank_q      <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        pend_sum_q[a] <= '0;
        sums_q[a]     <= '0;
      end
    end else begin
      pend_used_q <= pend_used_d;
      pend_refs_q <= pend_refs_d;
      seen_q      <= seen_d;
      mtri_q      <= mtri_d;
      pc_q        <= pc_d;
      bank_q      <= bank_d;
      pend_sum_q  <= pend_sum_d;
      sums_q      <= sums_d;
    end
  end

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !q_full_i) else $error("meshlet pushed into a full queue");
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ch.ready) else $error("transaction accepted while busy");
  a_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (push_entry_o.tri_cnt != 8'd0 &&
                push_entry_o.tri_cnt <= 8'(mbs_pkg::TriLimit)))
    else $error("meshlet with bad triangle count");

endmodule

`default_nettype wire

[sv/mbs_queue.sv]
// ----------------------------------------------------------------------------
// mbs_queue
// Two-entry meshlet queue; the head stays until the back end is done.
// ----------------------------------------------------------------------------
`default_nettype none

module mbs_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mbs_pkg::meshlet_t entry_i,
  input  logic              pop_i,
  output logic              valid_o,
  output logic              full_o,
  output mbs_pkg::meshlet_t head_o
);

  mbs_pkg::meshlet_t ent_q [2];
  logic [1:0] cnt_q;
  logic [1:0] wr_pos;

  assign valid_o = cnt_q != 2'd0;
  assign full_o  = cnt_q == 2'd2;
  assign head_o  = ent_q[0];
  assign wr_pos  = cnt_q - 2'(pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else         cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (pop_i) ent_q[0] <= ent_q[1];
    if (push_i) begin
      if (wr_pos == 2'd0) ent_q[0] <= entry_i;
      else                ent_q[1] <= entry_i;
    end
  end

endmodule

`default_nettype wire

[sv/mbs_back.sv]
// ----------------------------------------------------------------------------
// mbs_back
// Centroid divide, farthest-point walk and square root for one meshlet.
// ----------------------------------------------------------------------------
`default_nettype none

module mbs_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  mbs_pkg::meshlet_t head_i,
  output logic              pop_o,
  input  mbs_pkg::pt_wr_t   pt_wr_i,
  mbs_out_if.source         out_ch
);

  localparam int unsigned Aw = mbs_pkg::PointAw;
  localparam int unsigned Sw = mbs_pkg::SumW;
  localparam int unsigned Dw = mbs_pkg::DistW;

  mbs_pkg::back_state_e state_q;

  // point memory, two banks so the front can fill one while this walks the other
  mbs_pkg::point_t pmem [2][mbs_pkg::PointDepth];
  mbs_pkg::point_t rdata_q;
  logic [Aw-1:0]   rd_cnt_q;

  always_ff @(posedge clk_i) begin
    if (pt_wr_i.en) pmem[pt_wr_i.bank][pt_wr_i.addr] <= pt_wr_i.pt;
    rdata_q <= pmem[head_i.bank][rd_cnt_q];
  end

  // divider: restoring, one quotient bit per cycle on all three axes
  logic [Sw-1:0]    dvd_q [3];
  logic [Aw-1:0]    rem_q [3];
  logic             neg_q [3];
  logic [5:0]       div_cnt_q;
  logic [Sw-1:0]    dvd_n [3];
  logic [Aw-1:0]    rem_n [3];
  logic [Aw:0]      rem_sh [3];
  logic signed [Sw-1:0] sum_a [3];
  logic signed [31:0]   ctr_q [3];
  logic signed [Sw-1:0] quot_s [3];

  assign sum_a[0] = head_i.sum_x;
  assign sum_a[1] = head_i.sum_y;
  assign sum_a[2] = head_i.sum_z;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rem_sh[a] = {rem_q[a], dvd_q[a][Sw-1]};
      if (rem_sh[a] >= {1'b0, head_i.ref_cnt}) begin
        rem_n[a] = Aw'(rem_sh[a] - {1'b0, head_i.ref_cnt});
        dvd_n[a] = {dvd_q[a][Sw-2:0], 1'b1};
      end else begin
        rem_n[a] = rem_sh[a][Aw-1:0];
        dvd_n[a] = {dvd_q[a][Sw-2:0], 1'b0};
      end
      quot_s[a] = neg_q[a] ? -$signed(dvd_n[a]) : $signed(dvd_n[a]);
    end
  end

  // walk pipeline: read, difference, square, sum and max
  logic            v1_q, v2_q, v3_q;
  logic [32:0]     mag_q [3];
  logic [65:0]     sq_q [3];
  logic [Dw-1:0]   dmax_q;
  logic [Dw-1:0]   dsum;
  logic signed [31:0] pa [3];
  logic signed [32:0] diff [3];

  assign pa[0] = rdata_q.x;
  assign pa[1] = rdata_q.y;
  assign pa[2] = rdata_q.z;
  assign dsum  = Dw'(sq_q[0]) + Dw'(sq_q[1]) + Dw'(sq_q[2]);

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      diff[a] = 33'(pa[a]) - 33'(ctr_q[a]);
    end
  end

  // square root: bit-pair restoring method
  logic [Dw-1:0] op_q, res_q, one_q;
  logic [Dw-1:0] trial;
  logic [5:0]    root_cnt_q;
  assign trial = res_q + one_q;

  logic walk_issue;
  assign walk_issue = (state_q == mbs_pkg::BsWalk) && (rd_cnt_q != head_i.ref_cnt);

  // output register
  logic        ov_q;
  logic        load_out;
  assign load_out = (state_q == mbs_pkg::BsDone) && (!ov_q || out_ch.ready);
  assign pop_o    = load_out;
  assign out_ch.valid = ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mbs_pkg::BsIdle;
      ov_q     <= 1'b0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
    end else begin
      v1_q <= walk_issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (load_out)          ov_q <= 1'b1;
      else if (out_ch.ready) ov_q <= 1'b0;
      case (state_q)
        mbs_pkg::BsIdle: begin
          if (q_valid_i) begin
            if (head_i.ref_cnt == '0) state_q <= mbs_pkg::BsDone;
            else                      state_q <= mbs_pkg::BsDiv;
          end
        end
        mbs_pkg::BsDiv:  if (div_cnt_q == 6'd0) state_q <= mbs_pkg::BsWalk;
        mbs_pkg::BsWalk: begin
          if (!walk_issue && !v1_q && !v2_q && !v3_q) state_q <= mbs_pkg::BsRoot;
        end
        mbs_pkg::BsRoot: if (root_cnt_q == 6'd0) state_q <= mbs_pkg::BsDone;
        mbs_pkg::BsDone: if (load_out) state_q <= mbs_pkg::BsIdle;
        default:         state_q <= mbs_pkg::BsIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      mbs_pkg::BsIdle: begin
        div_cnt_q <= 6'(Sw - 1);
        rd_cnt_q  <= '0;
        dmax_q    <= '0;
        res_q     <= '0;
        for (int a = 0; a < 3; a++) begin
          neg_q[a] <= sum_a[a][Sw-1];
          dvd_q[a] <= sum_a[a][Sw-1] ? Sw'(-sum_a[a]) : Sw'(sum_a[a]);
          rem_q[a] <= '0;
          ctr_q[a] <= '0;
        end
      end
      mbs_pkg::BsDiv: begin
        div_cnt_q <= div_cnt_q - 6'd1;
        for (int a = 0; a < 3; a++) begin
          dvd_q[a] <= dvd_n[a];
          rem_q[a] <= rem_n[a];
          if (div_cnt_q == 6'd0) ctr_q[a] <= quot_s[a][31:0];
        end
      end
      mbs_pkg::BsWalk: begin
        if (walk_issue) rd_cnt_q <= rd_cnt_q + Aw'(1);
        if (v1_q) begin
          for (int a = 0; a < 3; a++) begin
            mag_q[a] <= diff[a][32] ? 33'(-diff[a]) : 33'(diff[a]);
          end
        end
        if (v2_q) begin
          for (int a = 0; a < 3; a++) sq_q[a] <= mag_q[a] * mag_q[a];
        end
        if (v3_q && dsum > dmax_q) dmax_q <= dsum;
        op_q       <= (v3_q && dsum > dmax_q) ? dsum : dmax_q;
        one_q      <= {2'b01, {(Dw-2){1'b0}}};
        root_cnt_q <= 6'(mbs_pkg::RootSteps - 1);
      end
      mbs_pkg::BsRoot: begin
        root_cnt_q <= root_cnt_q - 6'd1;
        one_q      <= one_q >> 2;
        if (op_q >= trial) begin
          op_q  <= op_q - trial;
          res_q <= (res_q >> 1) + one_q;
        end else begin
          res_q <= res_q >> 1;
        end
      end
      default: ;
    endcase
    if (load_out) begin
      out_ch.first_index     <= head_i.first_index;
      out_ch.triangle_count  <= head_i.tri_cnt;
      out_ch.reference_count <= head_i.ref_cnt;
      out_ch.center_x        <= ctr_q[0];
      out_ch.center_y        <= ctr_q[1];
      out_ch.center_z        <= ctr_q[2];
      out_ch.sphere_radius   <= res_q[32:0];
    end
  end

  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> q_valid_i) else $error("pop from an empty queue");
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mbs_pkg::BsWalk) |-> (rd_cnt_q <= head_i.ref_cnt))
    else $error("walk ran past the point count");
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ch.ready) |=> ov_q) else $error("result dropped while stalled");

endmodule

`default_nettype wire
